>>> rtl/core/pem_pkg.sv
// shared constants and types for the pulse energy meter with alarm led
// no dependencies; imported by the top level

package pem_pkg;

    // tick timing
    localparam logic [15:0] REPORT_TICKS  = 16'd60000;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;
    localparam int          LOCK_W        = 6;
    localparam logic [LOCK_W-1:0] LOCKOUT_TICKS = 6'd50;

    // counter widths and limits
    localparam int          INTV_W        = 16;
    localparam logic [INTV_W-1:0] INTV_MAX = 16'hFFFF;
    localparam int          TOTAL_W       = 32;
    localparam int          FLASH_W       = 10;
    localparam logic [FLASH_W-1:0] FLASH_MAX   = 10'd1023;
    localparam logic [FLASH_W-1:0] SLOW_PERIOD = 10'd1000;
    localparam logic [FLASH_W-1:0] FAST_PERIOD = 10'd200;

    // scaling: watts multiplier per interval and fixed point divisor
    localparam int          PPK_FRAC_BITS = 8;
    localparam int          PPK_W         = 15;
    localparam logic [PPK_W-1:0] PPK_RESET = PPK_W'(1 << PPK_FRAC_BITS);
    localparam logic [PPK_W-1:0] PPK_MAX   = PPK_W'((100 << PPK_FRAC_BITS) - 1);
    localparam int          WATT_MULT_INT = 3600000 / int'(REPORT_TICKS);
    localparam int          WATT_W        = $clog2(WATT_MULT_INT + 1);
    localparam logic [WATT_W-1:0] WATT_MULT = WATT_W'(WATT_MULT_INT);
    localparam int          MUL_W         = INTV_W + WATT_W;

    // restoring divider: one quotient bit per cycle
    localparam int          NUM_W         = TOTAL_W + PPK_FRAC_BITS;
    localparam int          CNT_W         = $clog2(NUM_W);
    localparam int          READ_W        = 31;
    localparam logic [READ_W-1:0] SAT31   = {READ_W{1'b1}};

    // register map (index = paddr word)
    localparam logic REG_PPK        = 1'b0;
    localparam logic REG_ALARM_MODE = 1'b1;

    // led mode codes
    localparam logic [1:0] LED_OFF  = 2'd0;
    localparam logic [1:0] LED_ON   = 2'd1;
    localparam logic [1:0] LED_SLOW = 2'd2;
    localparam logic [1:0] LED_FAST = 2'd3;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = 3 + 2 * READ_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } state_t;

endpackage

>>> rtl/core/pulse_energy_meter_with_alarm_led_unit.sv
// pulse energy meter with alarm led: pulse counting, periodic power and
// energy reports through a bit-serial divider, led flasher
// depends on pem_pkg
//
//  channel   dir   handshake              payload
//  s_*       in    s_tvalid / s_tready    s_tdata[0] pulse_level, [1] clear_total
//  m_*       out   m_tvalid / m_tready    m_tdata: indicator, led, report, power, energy
//  apb       in    psel,penable,pwrite    reg 0 pulses_per_kwh @0, reg 1 alarm_mode @4
//
// an ordinary tick's result goes to the output register at the edge the item
// is accepted. a report tick passes through the accept cycle, the restoring
// divider (one quotient bit per cycle over a 40 bit numerator, power and
// energy in parallel) and the hold state, which saturates and loads the
// result; a full output register stretches the hold. a new item is taken
// only in idle, while the output register is empty or being drained.
// reset is asynchronous, active low, and clears all counters and control.

module pulse_energy_meter_with_alarm_led_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // stream in: tdata = pulse_level, clear_total, zero pad (lsb first)
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pem_pkg::IN_TDATA_W-1:0]    s_tdata,
    // stream out: tdata = pulse_indicator, alarm_led, report_valid,
    // power_reading[30:0], energy_reading[30:0], zero pad (lsb first)
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pem_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import pem_pkg::*;

    // configuration registers
    logic [PPK_W-1:0]   ppk_reg;
    logic [1:0]         alarm_mode_reg;

    // meter state
    logic               last_level_reg,   last_level_next;
    logic [LOCK_W-1:0]  lockout_reg,      lockout_next;
    logic [INTV_W-1:0]  intv_reg,         intv_next;
    logic [TOTAL_W-1:0] total_reg,        total_next;
    logic [15:0]        ticks_reg,        ticks_next;
    logic               reported_reg,     reported_next;
    logic               led_reg,          led_next;
    logic [FLASH_W-1:0] flash_reg,        flash_next;

    // divider
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [NUM_W-1:0]   pnq_reg,   pnq_next;   // power numerator, becomes quotient
    logic [NUM_W-1:0]   enq_reg,   enq_next;   // energy numerator, becomes quotient
    logic [PPK_W-1:0]   prem_reg,  prem_next;
    logic [PPK_W-1:0]   erem_reg,  erem_next;

    // output register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   o_ind_reg,    o_ind_next;
    logic                   o_led_reg,    o_led_next;
    logic                   o_rep_reg,    o_rep_next;
    logic [READ_W-1:0]      o_pwr_reg,    o_pwr_next;
    logic [READ_W-1:0]      o_eng_reg,    o_eng_next;

    // fsm outputs
    logic               out_free;
    logic               accept;
    logic               div_run;
    logic               hold_load;

    // tick datapath
    logic               lvl_in;
    logic               clr_in;
    logic               report_now;
    logic [INTV_W-1:0]  intv_mid;
    logic [TOTAL_W-1:0] total_mid;
    logic [MUL_W-1:0]   intv_mult;
    logic [FLASH_W-1:0] flash_inc;
    logic [FLASH_W-1:0] period;

    // divider step
    logic [PPK_W:0]     ptrial, etrial;
    logic               pbit,   ebit;

    // configuration write
    logic               cfg_wr;
    logic [PPK_W-1:0]   wr_ppk;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign wr_ppk = pwdata[PPK_W-1:0];

    always_comb
    begin
        unique case (paddr[2])
            REG_PPK:        prdata = {{(32-PPK_W){1'b0}}, ppk_reg};
            REG_ALARM_MODE: prdata = {30'd0, alarm_mode_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // bad divisor writes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppk_reg        <= PPK_RESET;
            alarm_mode_reg <= LED_OFF;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_PPK)
            begin
                if (wr_ppk != '0 && wr_ppk <= PPK_MAX)
                begin
                    ppk_reg <= wr_ppk;
                end
            end
            else
            begin
                alarm_mode_reg <= pwdata[1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // control fsm
    // ---------------------------------------------------------------
    assign out_free = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && report_now)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        div_run   = 1'b0;
        hold_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready  = out_free;
            ST_DIV:  div_run   = 1'b1;
            ST_HOLD: hold_load = out_free;
            default: s_tready  = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------
    // per tick update: clear, pulse edge with lockout, report, led
    // ---------------------------------------------------------------
    assign lvl_in = s_tdata[0];
    assign clr_in = s_tdata[1];

    always_comb
    begin
        last_level_next = last_level_reg;
        lockout_next    = lockout_reg;
        intv_next       = intv_reg;
        total_next      = total_reg;
        ticks_next      = ticks_reg;
        reported_next   = reported_reg;
        led_next        = led_reg;
        flash_next      = flash_reg;
        intv_mid        = intv_reg;
        total_mid       = clr_in ? '0 : total_reg;
        report_now      = 1'b0;
        flash_inc       = (flash_reg < FLASH_MAX) ? flash_reg + 1'b1 : flash_reg;
        period          = (alarm_mode_reg == LED_SLOW) ? SLOW_PERIOD : FAST_PERIOD;

        // falling edge counts once, then the line is ignored for the lockout
        if (lockout_reg != '0)
        begin
            lockout_next = lockout_reg - 1'b1;
        end
        else if (!lvl_in && last_level_reg)
        begin
            if (intv_reg < INTV_MAX)
            begin
                intv_mid = intv_reg + 1'b1;
            end
            total_mid       = total_mid + 1'b1;
            last_level_next = 1'b0;
            lockout_next    = LOCKOUT_TICKS;
        end
        else if (lvl_in)
        begin
            last_level_next = 1'b1;
        end

        if (reported_reg && ticks_reg < TICKS_MAX)
        begin
            ticks_next = ticks_reg + 1'b1;
        end
        intv_next  = intv_mid;
        total_next = total_mid;
        // first tick always reports
        if (!reported_reg || ticks_next >= REPORT_TICKS)
        begin
            report_now    = 1'b1;
            intv_next     = '0;
            ticks_next    = '0;
            reported_next = 1'b1;
        end

        // a forced level restarts the flash timer only when it changes
        case (alarm_mode_reg) inside
            LED_OFF:
            begin
                if (led_reg)
                begin
                    led_next   = 1'b0;
                    flash_next = '0;
                end
                else
                begin
                    flash_next = flash_inc;
                end
            end
            LED_ON:
            begin
                if (!led_reg)
                begin
                    led_next   = 1'b1;
                    flash_next = '0;
                end
                else
                begin
                    flash_next = flash_inc;
                end
            end
            LED_SLOW, LED_FAST:
            begin
                if (flash_inc >= period)
                begin
                    led_next   = !led_reg;
                    flash_next = '0;
                end
                else
                begin
                    flash_next = flash_inc;
                end
            end
            default: flash_next = flash_inc;
        endcase
    end

    assign intv_mult = MUL_W'(intv_mid * WATT_MULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b1;
            lockout_reg    <= '0;
            intv_reg       <= '0;
            total_reg      <= '0;
            ticks_reg      <= '0;
            reported_reg   <= 1'b0;
            led_reg        <= 1'b0;
            flash_reg      <= '0;
        end
        else if (accept)
        begin
            last_level_reg <= last_level_next;
            lockout_reg    <= lockout_next;
            intv_reg       <= intv_next;
            total_reg      <= total_next;
            ticks_reg      <= ticks_next;
            reported_reg   <= reported_next;
            led_reg        <= led_next;
            flash_reg      <= flash_next;
        end
    end

    // ---------------------------------------------------------------
    // restoring divider, one bit per cycle; the numerator register shifts
    // left and takes the quotient bit in at the bottom
    // ---------------------------------------------------------------
    assign ptrial = {prem_reg, pnq_reg[NUM_W-1]};
    assign etrial = {erem_reg, enq_reg[NUM_W-1]};
    assign pbit   = ptrial >= {1'b0, ppk_reg};
    assign ebit   = etrial >= {1'b0, ppk_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        pnq_next  = pnq_reg;
        enq_next  = enq_reg;
        prem_next = prem_reg;
        erem_next = erem_reg;
        if (accept && report_now)
        begin
            cnt_next  = '0;
            pnq_next  = NUM_W'(intv_mult) << PPK_FRAC_BITS;
            enq_next  = NUM_W'(total_mid) << PPK_FRAC_BITS;
            prem_next = '0;
            erem_next = '0;
        end
        else if (div_run)
        begin
            cnt_next  = cnt_reg + 1'b1;
            pnq_next  = {pnq_reg[NUM_W-2:0], pbit};
            enq_next  = {enq_reg[NUM_W-2:0], ebit};
            prem_next = pbit ? PPK_W'(ptrial - {1'b0, ppk_reg}) : ptrial[PPK_W-1:0];
            erem_next = ebit ? PPK_W'(etrial - {1'b0, ppk_reg}) : etrial[PPK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pnq_reg  <= pnq_next;
        enq_reg  <= enq_next;
        prem_reg <= prem_next;
        erem_reg <= erem_next;
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        o_ind_next    = o_ind_reg;
        o_led_next    = o_led_reg;
        o_rep_next    = o_rep_reg;
        o_pwr_next    = o_pwr_reg;
        o_eng_next    = o_eng_reg;
        if (accept && !report_now)
        begin
            m_tvalid_next = 1'b1;
            o_ind_next    = last_level_next;
            o_led_next    = led_next;
            o_rep_next    = 1'b0;
            o_pwr_next    = '0;
            o_eng_next    = '0;
        end
        else if (hold_load)
        begin
            // meter state already holds this tick's levels
            m_tvalid_next = 1'b1;
            o_ind_next    = last_level_reg;
            o_led_next    = led_reg;
            o_rep_next    = 1'b1;
            o_pwr_next    = (pnq_reg[NUM_W-1:READ_W] != '0) ? SAT31 : pnq_reg[READ_W-1:0];
            o_eng_next    = (enq_reg[NUM_W-1:READ_W] != '0) ? SAT31 : enq_reg[READ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_ind_reg <= o_ind_next;
        o_led_reg <= o_led_next;
        o_rep_reg <= o_rep_next;
        o_pwr_reg <= o_pwr_next;
        o_eng_reg <= o_eng_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}},
                       o_eng_reg, o_pwr_reg, o_rep_reg, o_led_reg, o_ind_reg};

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_ppk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ppk_reg != '0 && ppk_reg <= PPK_MAX)
        else $error("divisor register out of range");

    a_report_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        accept && report_now |=> state_reg == ST_DIV && cnt_reg == '0)
        else $error("report tick did not start the divider");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg <= CNT_W'(NUM_W - 1))
        else $error("divider ran past its bit count");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !s_tready)
        else $error("item taken while a report is in progress");

    a_quiet_readings: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !o_rep_reg |-> o_pwr_reg == '0 && o_eng_reg == '0)
        else $error("readings present without a report");

endmodule
